// ===== design/pcls_pkg.sv =====
// ----------------------------------------------------------------------------
// pcls_pkg
// Shared types and constants of the pedestrian crossing light sequencer:
// configuration register indexes, reset values, lamp bit positions.
// ----------------------------------------------------------------------------
package pcls_pkg;

    localparam int unsigned DurW     = 16;
    localparam int unsigned BeepW    = 4;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned LampW    = 6;
    localparam int unsigned PhaseW   = 4;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_GREEN     = 3'd0,
        REG_YELLOW    = 3'd1,
        REG_RED       = 3'd2,
        REG_WALK      = 3'd3,
        REG_BEEP_HALF = 3'd4,
        REG_BEEP_CNT  = 3'd5,
        REG_CLEAR     = 3'd6,
        REG_DEBOUNCE  = 3'd7
    } cfg_idx_t;

    // reset values
    localparam logic [DurW-1:0]  GreenRst    = 16'd5000;
    localparam logic [DurW-1:0]  YellowRst   = 16'd2000;
    localparam logic [DurW-1:0]  RedRst      = 16'd3000;
    localparam logic [DurW-1:0]  WalkRst     = 16'd4000;
    localparam logic [DurW-1:0]  BeepHalfRst = 16'd200;
    localparam logic [BeepW-1:0] BeepCntRst  = 4'd4;
    localparam logic [DurW-1:0]  ClearRst    = 16'd1000;
    localparam logic [DurW-1:0]  DebounceRst = 16'd50;

    // lamp bit positions
    localparam int unsigned LampCarRed    = 0;
    localparam int unsigned LampCarYellow = 1;
    localparam int unsigned LampCarGreen  = 2;
    localparam int unsigned LampWalkRed   = 3;
    localparam int unsigned LampWalkGreen = 4;
    localparam int unsigned LampBuzzer    = 5;

    // current register set handed to the sequencer core
    typedef struct packed {
        logic [DurW-1:0]  green_ticks;
        logic [DurW-1:0]  yellow_ticks;
        logic [DurW-1:0]  red_ticks;
        logic [DurW-1:0]  walk_ticks;
        logic [DurW-1:0]  beep_half_ticks;
        logic [BeepW-1:0] beep_total;
        logic [DurW-1:0]  clear_ticks;
        logic [DurW-1:0]  debounce_ticks;
    } cfg_t;

endpackage

// ===== design/pcls_cfg.sv =====
// ----------------------------------------------------------------------------
// pcls_cfg
// Configuration register file: plain indexed write port, no read-back.
// ----------------------------------------------------------------------------
module pcls_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pcls_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [pcls_pkg::CfgDataW-1:0]  cfg_wdata,
    output pcls_pkg::cfg_t                 cfg
);
    import pcls_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_GREEN:     cfg_next.green_ticks     = cfg_wdata;
                REG_YELLOW:    cfg_next.yellow_ticks    = cfg_wdata;
                REG_RED:       cfg_next.red_ticks       = cfg_wdata;
                REG_WALK:      cfg_next.walk_ticks      = cfg_wdata;
                REG_BEEP_HALF: cfg_next.beep_half_ticks = cfg_wdata;
                REG_BEEP_CNT:  cfg_next.beep_total      = cfg_wdata[BeepW-1:0];
                REG_CLEAR:     cfg_next.clear_ticks     = cfg_wdata;
                REG_DEBOUNCE:  cfg_next.debounce_ticks  = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // register set with reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.green_ticks     <= GreenRst;
            cfg_reg.yellow_ticks    <= YellowRst;
            cfg_reg.red_ticks       <= RedRst;
            cfg_reg.walk_ticks      <= WalkRst;
            cfg_reg.beep_half_ticks <= BeepHalfRst;
            cfg_reg.beep_total      <= BeepCntRst;
            cfg_reg.clear_ticks     <= ClearRst;
            cfg_reg.debounce_ticks  <= DebounceRst;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/pcls_core.sv =====
// ----------------------------------------------------------------------------
// pcls_core
// Phase sequencer: one tick item per cycle (while the result register is free or draining) updates phase, tick
// counter, beep count and lamp levels; the levels before the update go to a result register.
// ----------------------------------------------------------------------------
module pcls_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pcls_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_button_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pcls_pkg::LampW-1:0]    m_lamps,
    output logic [pcls_pkg::PhaseW-1:0]   m_phase_now
);
    import pcls_pkg::*;

    typedef enum logic [PhaseW-1:0] {
        PH_DECIDE   = 4'd0,
        PH_DEBOUNCE = 4'd1,
        PH_GREEN    = 4'd2,
        PH_YELLOW   = 4'd3,
        PH_RED      = 4'd4,
        PH_WALK     = 4'd5,
        PH_BEEP_ON  = 4'd6,
        PH_BEEP_OFF = 4'd7,
        PH_CLEAR    = 4'd8
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [DurW-1:0]     tick_reg, tick_next;
    logic [BeepW-1:0]    beeps_reg, beeps_next;
    logic [LampW-1:0]    lamps_reg, lamps_next;
    logic                m_valid_reg;
    logic [LampW-1:0]    out_lamps_reg;
    logic [PhaseW-1:0]   out_phase_reg;

    logic                s_fire;
    logic [DurW-1:0]     dur;
    logic [DurW:0]       tick_inc;
    logic                done;
    logic [BeepW-1:0]    beeps_inc;

    // a new item enters whenever the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // duration of the current phase
    always_comb begin
        case (phase_reg)
            PH_DEBOUNCE: dur = cfg.debounce_ticks;
            PH_GREEN:    dur = cfg.green_ticks;
            PH_YELLOW:   dur = cfg.yellow_ticks;
            PH_RED:      dur = cfg.red_ticks;
            PH_WALK:     dur = cfg.walk_ticks;
            PH_BEEP_ON:  dur = cfg.beep_half_ticks;
            PH_BEEP_OFF: dur = cfg.beep_half_ticks;
            PH_CLEAR:    dur = cfg.clear_ticks;
            default:     dur = {{(DurW-1){1'b0}}, 1'b1};
        endcase
    end

    assign tick_inc  = {1'b0, tick_reg} + {{DurW{1'b0}}, 1'b1};
    assign done      = tick_inc >= {1'b0, dur};
    assign beeps_inc = beeps_reg + {{(BeepW-1){1'b0}}, 1'b1};

    // phase transitions and lamp updates
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_inc[DurW-1:0];
        beeps_next = beeps_reg;
        lamps_next = lamps_reg;
        if (done) begin
            tick_next = '0;
            case (phase_reg)
                PH_DECIDE, PH_DEBOUNCE, PH_CLEAR: begin
                    if (phase_reg != PH_CLEAR && s_button_level) begin
                        if (phase_reg == PH_DECIDE) begin
                            phase_next = PH_DEBOUNCE;
                        end else begin
                            // walk: cars red, walkers green
                            lamps_next[LampCarGreen]  = 1'b0;
                            lamps_next[LampCarYellow] = 1'b0;
                            lamps_next[LampWalkRed]   = 1'b0;
                            lamps_next[LampCarRed]    = 1'b1;
                            lamps_next[LampWalkGreen] = 1'b1;
                            phase_next = PH_WALK;
                        end
                    end else begin
                        // vehicle green
                        lamps_next[LampWalkRed]  = 1'b1;
                        lamps_next[LampCarGreen] = 1'b1;
                        lamps_next[LampCarRed]   = 1'b0;
                        phase_next = PH_GREEN;
                    end
                end
                PH_GREEN: begin
                    lamps_next[LampCarGreen]  = 1'b0;
                    lamps_next[LampCarYellow] = 1'b1;
                    phase_next = PH_YELLOW;
                end
                PH_YELLOW: begin
                    lamps_next[LampCarYellow] = 1'b0;
                    lamps_next[LampCarRed]    = 1'b1;
                    phase_next = PH_RED;
                end
                PH_RED: begin
                    phase_next = PH_DECIDE;
                end
                PH_WALK, PH_BEEP_OFF: begin
                    if (phase_reg == PH_WALK) begin
                        beeps_next = '0;
                    end else begin
                        beeps_next = beeps_inc;
                    end
                    if (beeps_next >= cfg.beep_total) begin
                        // pedestrian clearance
                        lamps_next[LampWalkGreen] = 1'b0;
                        lamps_next[LampWalkRed]   = 1'b1;
                        phase_next = PH_CLEAR;
                    end else begin
                        lamps_next[LampBuzzer] = 1'b1;
                        phase_next = PH_BEEP_ON;
                    end
                end
                PH_BEEP_ON: begin
                    lamps_next[LampBuzzer] = 1'b0;
                    phase_next = PH_BEEP_OFF;
                end
                default: begin
                    phase_next = PH_DECIDE;
                end
            endcase
        end
    end

    // sequencer state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DECIDE;
            tick_reg    <= '0;
            beeps_reg   <= '0;
            lamps_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                beeps_reg   <= beeps_next;
                lamps_reg   <= lamps_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: levels as they stood during the tick
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_lamps_reg <= lamps_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_lamps     = out_lamps_reg;
    assign m_phase_now = out_phase_reg;

endmodule

// ===== design/pedestrian_crossing_light_sequencer_unit.sv =====
// The result of a tick item is registered: it is valid in the cycle after the item is accepted.
// Throughput: one tick item per cycle while no result waits; the phase update is a single combinational step.
// A waiting result holds off the input; the next item enters in the cycle it drains.
// Reset (aresetn low, synchronous): phase decide, counters and lamps cleared,
// configuration registers back to their reset values.
// ----------------------------------------------------------------------------
// pedestrian_crossing_light_sequencer_unit
// Top level: configuration registers and the phase sequencer core.
// ----------------------------------------------------------------------------
module pedestrian_crossing_light_sequencer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pcls_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [pcls_pkg::CfgDataW-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_button_level,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_car_red,
    output logic                           m_car_yellow,
    output logic                           m_car_green,
    output logic                           m_walker_red,
    output logic                           m_walker_green,
    output logic                           m_buzzer_on,
    output logic [pcls_pkg::PhaseW-1:0]    m_phase_now
);
    import pcls_pkg::*;

    cfg_t             cfg;
    logic [LampW-1:0] lamps;

    // register file
    pcls_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // phase sequencer
    pcls_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lamps        (lamps),
        .m_phase_now    (m_phase_now)
    );

    // split the lamp vector onto the result ports
    assign m_car_red      = lamps[LampCarRed];
    assign m_car_yellow   = lamps[LampCarYellow];
    assign m_car_green    = lamps[LampCarGreen];
    assign m_walker_red   = lamps[LampWalkRed];
    assign m_walker_green = lamps[LampWalkGreen];
    assign m_buzzer_on    = lamps[LampBuzzer];

endmodule

// ===== verif/tb_pedestrian_crossing_light_sequencer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pedestrian_crossing_light_sequencer_unit
// Self-checking bench for the crossing light sequencer. Tick items carrying
// the button level go in over a valid/ready channel. A tracker class keeps
// its own copy of the registers, phase, tick counter, beep counter and lamps.
// It predicts the lamp and phase item of every accepted tick and checks each
// returned item against the oldest prediction. A directed opening covers the
// special timing cases. Random register settings and button patterns follow,
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_pedestrian_crossing_light_sequencer_unit;
    import pcls_pkg::*;

    localparam int unsigned CycleLimit = 300000;

    typedef enum logic [PhaseW-1:0] {
        PHASE_DECIDE   = 4'd0,
        PHASE_DEBOUNCE = 4'd1,
        PHASE_GREEN    = 4'd2,
        PHASE_YELLOW   = 4'd3,
        PHASE_RED      = 4'd4,
        PHASE_WALK     = 4'd5,
        PHASE_BEEP_ON  = 4'd6,
        PHASE_BEEP_OFF = 4'd7,
        PHASE_CLEAR    = 4'd8
    } seq_phase_t;

    typedef struct packed {
        logic              car_red;
        logic              car_yellow;
        logic              car_green;
        logic              walker_red;
        logic              walker_green;
        logic              buzzer_on;
        logic [PhaseW-1:0] phase_now;
    } lamp_rec_t;

    // tracks the crossing state and holds the lamp items still due
    class crossing_tracker;
        logic [DurW-1:0]  regs [0:7];
        seq_phase_t       phase;
        logic [DurW-1:0]  spent;
        logic [BeepW-1:0] beeps;
        logic [LampW-1:0] lamps;
        lamp_rec_t        lamps_due [$];
        int unsigned      errors;

        function new();
            regs[REG_GREEN]     = GreenRst;
            regs[REG_YELLOW]    = YellowRst;
            regs[REG_RED]       = RedRst;
            regs[REG_WALK]      = WalkRst;
            regs[REG_BEEP_HALF] = BeepHalfRst;
            regs[REG_BEEP_CNT]  = {{(DurW-BeepW){1'b0}}, BeepCntRst};
            regs[REG_CLEAR]     = ClearRst;
            regs[REG_DEBOUNCE]  = DebounceRst;
            phase  = PHASE_DECIDE;
            spent  = '0;
            beeps  = '0;
            lamps  = '0;
            errors = 0;
        endfunction

        function void load_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
            if (idx == REG_BEEP_CNT) begin
                regs[idx] = {{(DurW-BeepW){1'b0}}, val[BeepW-1:0]};
            end else begin
                regs[idx] = val;
            end
        endfunction

        function int unsigned pending();
            return lamps_due.size();
        endfunction

        function void go_to(seq_phase_t p);
            phase = p;
            spent = '0;
        endfunction

        function void go_green();
            lamps[LampWalkRed]  = 1'b1;
            lamps[LampCarGreen] = 1'b1;
            lamps[LampCarRed]   = 1'b0;
            go_to(PHASE_GREEN);
        endfunction

        function void go_clear();
            lamps[LampWalkGreen] = 1'b0;
            lamps[LampWalkRed]   = 1'b1;
            go_to(PHASE_CLEAR);
        endfunction

        function void go_beep();
            lamps[LampBuzzer] = 1'b1;
            go_to(PHASE_BEEP_ON);
        endfunction

        // lamps shown during this tick, then the phase update
        function void predict_tick(logic btn);
            lamp_rec_t       rec;
            logic [DurW-1:0] limit;
            rec.car_red      = lamps[LampCarRed];
            rec.car_yellow   = lamps[LampCarYellow];
            rec.car_green    = lamps[LampCarGreen];
            rec.walker_red   = lamps[LampWalkRed];
            rec.walker_green = lamps[LampWalkGreen];
            rec.buzzer_on    = lamps[LampBuzzer];
            rec.phase_now    = phase;
            lamps_due.push_back(rec);

            case (phase)
                PHASE_DEBOUNCE: limit = regs[REG_DEBOUNCE];
                PHASE_GREEN:    limit = regs[REG_GREEN];
                PHASE_YELLOW:   limit = regs[REG_YELLOW];
                PHASE_RED:      limit = regs[REG_RED];
                PHASE_WALK:     limit = regs[REG_WALK];
                PHASE_BEEP_ON, PHASE_BEEP_OFF: limit = regs[REG_BEEP_HALF];
                PHASE_CLEAR:    limit = regs[REG_CLEAR];
                default:        limit = 16'd1;
            endcase

            // phase still running
            if (32'(spent) + 1 < 32'(limit)) begin
                spent = spent + 16'd1;
                return;
            end

            case (phase)
                PHASE_DECIDE: begin
                    if (btn) go_to(PHASE_DEBOUNCE);
                    else go_green();
                end
                PHASE_DEBOUNCE: begin
                    if (btn) begin
                        lamps[LampCarGreen]  = 1'b0;
                        lamps[LampCarYellow] = 1'b0;
                        lamps[LampWalkRed]   = 1'b0;
                        lamps[LampCarRed]    = 1'b1;
                        lamps[LampWalkGreen] = 1'b1;
                        go_to(PHASE_WALK);
                    end else begin
                        go_green();
                    end
                end
                PHASE_GREEN: begin
                    lamps[LampCarGreen]  = 1'b0;
                    lamps[LampCarYellow] = 1'b1;
                    go_to(PHASE_YELLOW);
                end
                PHASE_YELLOW: begin
                    lamps[LampCarYellow] = 1'b0;
                    lamps[LampCarRed]    = 1'b1;
                    go_to(PHASE_RED);
                end
                PHASE_RED: go_to(PHASE_DECIDE);
                PHASE_WALK: begin
                    beeps = '0;
                    if (regs[REG_BEEP_CNT][BeepW-1:0] == '0) go_clear();
                    else go_beep();
                end
                PHASE_BEEP_ON: begin
                    lamps[LampBuzzer] = 1'b0;
                    go_to(PHASE_BEEP_OFF);
                end
                PHASE_BEEP_OFF: begin
                    beeps = beeps + 4'd1;
                    if (beeps >= regs[REG_BEEP_CNT][BeepW-1:0]) go_clear();
                    else go_beep();
                end
                PHASE_CLEAR: go_green();
                default: go_to(PHASE_DECIDE);
            endcase
        endfunction

        function string show(lamp_rec_t r);
            return $sformatf("car r%0d y%0d g%0d walk r%0d g%0d buzz %0d phase %0d",
                r.car_red, r.car_yellow, r.car_green, r.walker_red,
                r.walker_green, r.buzzer_on, r.phase_now);
        endfunction

        function void check_lamps(lamp_rec_t got);
            lamp_rec_t want;
            if (lamps_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("lamp item with none due: %s", show(got));
                return;
            end
            want = lamps_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("lamp mismatch: expected %s", show(want));
                    $display("               actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CfgIdxW-1:0]    cfg_index;
    logic [CfgDataW-1:0]   cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_button_level;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_car_red;
    logic                  m_car_yellow;
    logic                  m_car_green;
    logic                  m_walker_red;
    logic                  m_walker_green;
    logic                  m_buzzer_on;
    logic [PhaseW-1:0]     m_phase_now;

    crossing_tracker tracker;
    bit              src_gaps;
    logic            btn_now;
    int              btn_left;
    int unsigned     cycle_count;

    pedestrian_crossing_light_sequencer_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_car_red      (m_car_red),
        .m_car_yellow   (m_car_yellow),
        .m_car_green    (m_car_green),
        .m_walker_red   (m_walker_red),
        .m_walker_green (m_walker_green),
        .m_buzzer_on    (m_buzzer_on),
        .m_phase_now    (m_phase_now)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("pedestrian_crossing_light_sequencer_unit regression: fail");
            $finish;
        end
    end

    // button pattern: held levels of random length, mostly pressed
    function automatic logic next_button();
        if (btn_left == 0) begin
            btn_now  = ($urandom_range(0, 9) < 7);
            btn_left = $urandom_range(1, 6);
        end
        btn_left--;
        return btn_now;
    endfunction

    // offer one tick item; called and returns at a falling edge
    task automatic send_tick(input logic lvl);
        int gap;
        gap = src_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_button_level <= lvl;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.predict_tick(lvl);
        @(negedge aclk);
    endtask

    // stop offering and wait for every due lamp item
    task automatic drain_outputs();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.load_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_to_phase(input seq_phase_t target, input logic lvl);
        int guard;
        guard = 0;
        while (tracker.phase != target && guard < 300) begin
            send_tick(lvl);
            guard++;
        end
    endtask

    // random register set: short durations, now and then zero or longer
    task automatic load_settings(input int pick);
        logic [CfgDataW-1:0] val;
        int                  r;
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 15);
            if (r == 0) val = '0;
            else if (r < 3) val = 16'($urandom_range(5, 12));
            else val = 16'($urandom_range(1, 4));
            if (cfg_idx_t'(i) == REG_BEEP_CNT) begin
                if (pick == 0) val = '0;
                else if (pick == 1) val = 16'd15;
                else val = 16'($urandom_range(0, 15));
            end
            if (pick == 1 && cfg_idx_t'(i) == REG_BEEP_HALF) val = 16'd1;
            write_reg(cfg_idx_t'(i), val);
        end
    endtask

    // result side: random stalls, one long hold
    initial begin : lamp_sink
        int        stall;
        int        results_seen;
        bit        sink_gaps;
        lamp_rec_t got;
        results_seen = 0;
        sink_gaps    = 1'b1;
        m_ready      = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (results_seen % 40 == 0) sink_gaps = ($urandom_range(0, 3) != 0);
            stall = sink_gaps ? $urandom_range(0, 12) : 0;
            // long hold while ticks keep coming, backs the block up
            if (results_seen == 150) stall = 120;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got = {m_car_red, m_car_yellow, m_car_green, m_walker_red,
                   m_walker_green, m_buzzer_on, m_phase_now};
            tracker.check_lamps(got);
            results_seen++;
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin : tick_source
        tracker        = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_button_level = 1'b0;
        src_gaps       = 1'b1;
        btn_now        = 1'b0;
        btn_left       = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset durations: press in decide, then partway into debounce
        send_tick(1'b1);
        send_tick(1'b1);
        drain_outputs();

        // short durations, zero clearance, debounce cut below ticks spent
        write_reg(REG_GREEN, 16'd2);
        write_reg(REG_YELLOW, 16'd1);
        write_reg(REG_RED, 16'd1);
        write_reg(REG_WALK, 16'd2);
        write_reg(REG_BEEP_HALF, 16'd1);
        write_reg(REG_BEEP_CNT, 16'd3);
        write_reg(REG_CLEAR, 16'd0);
        write_reg(REG_DEBOUNCE, 16'd1);
        run_to_phase(PHASE_BEEP_OFF, 1'b1);
        drain_outputs();

        // beep count lowered in the middle of the first beep
        write_reg(REG_BEEP_CNT, 16'd1);
        repeat (6) send_tick(1'b0);
        drain_outputs();

        // every duration at its maximum, fifteen beeps
        for (int i = 0; i < 8; i++) begin
            write_reg(cfg_idx_t'(i), (cfg_idx_t'(i) == REG_BEEP_CNT) ? 16'd15 : 16'hFFFF);
        end
        repeat (4) send_tick(1'b1);
        drain_outputs();

        // debounce shortened mid-phase with the button released: no walk
        write_reg(REG_DEBOUNCE, 16'd2);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_outputs();
        write_reg(REG_GREEN, 16'd0);
        send_tick(1'b0);
        send_tick(1'b1);

        // random settings and button patterns
        for (int ph = 0; ph < 10; ph++) begin
            drain_outputs();
            load_settings(ph);
            src_gaps = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 40; n++) begin
                // sender waits once for every due item mid-sequence
                if (ph == 5 && n == 20) drain_outputs();
                send_tick(next_button());
            end
        end

        drain_outputs();
        repeat (10) @(negedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("pedestrian_crossing_light_sequencer_unit regression: pass");
        end else begin
            $display("pedestrian_crossing_light_sequencer_unit regression: fail");
        end
        $finish;
    end

endmodule
